// ===== design/drf_pkg.sv =====
// ----------------------------------------------------------------------------
// drf_pkg
// Shared types and constants for the DMA request packet framer.
// ----------------------------------------------------------------------------
package drf_pkg;

    localparam int BODY_BYTES  = 44;
    localparam int FRAME_BYTES = BODY_BYTES + 7;
    localparam int MAX_LENGTH  = 8192;

    localparam int ADDR_W  = 32;
    localparam int LEN_W   = 14;
    localparam int BYTE_W  = 8;
    localparam int PADDR_W = 16;
    localparam int POS_W   = $clog2(FRAME_BYTES);
    localparam int SIZE_W  = $clog2(BODY_BYTES + 1);

    // Frame positions
    localparam int POS_SOF      = 0;
    localparam int POS_COUNT    = 1;
    localparam int POS_OPCODE   = 2;
    localparam int POS_ADDR0    = 3;
    localparam int POS_ADDR1    = 4;
    localparam int POS_ADDR2    = 5;
    localparam int POS_ADDR3    = 6;
    localparam int POS_BODY     = 5;
    localparam int POS_LAST_SUM = BODY_BYTES + 4;
    localparam int POS_CHECKSUM = BODY_BYTES + 5;
    localparam int POS_EOF      = BODY_BYTES + 6;

    localparam logic [BYTE_W-1:0] FRAME_START = 8'h87;
    localparam logic [BYTE_W-1:0] FRAME_END   = 8'h0D;

    // ceil(length / BODY_BYTES) by reciprocal multiply; exact for 14-bit operands
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + BODY_BYTES - 1) / BODY_BYTES;
    localparam int RECIP_W     = $clog2(RECIP + 1);
    localparam int PROD_W      = LEN_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_OPCODE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_OPCODE = 1'b1;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data_byte;
    } drf_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] frame_byte;
        logic              end_of_frame;
        logic              last;
    } drf_frm_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_opcode;
        logic [BYTE_W-1:0] write_opcode;
    } drf_cfg_t;

    // Emission plan for one accepted item
    typedef struct packed {
        logic               is_read;
        logic [BYTE_W-1:0]  count;
        logic [ADDR_W-1:0]  address;
        logic [SIZE_W-1:0]  size;
        logic [PADDR_W-1:0] pkt_addr;
        logic [BYTE_W-1:0]  data;
        logic [POS_W-1:0]   first_pos;
        logic [POS_W-1:0]   data_pos;
        logic [POS_W-1:0]   last_pos;
    } drf_plan_t;

endpackage

// ===== design/drf_decoder.sv =====
// ----------------------------------------------------------------------------
// drf_decoder
// Tracks write transfer state; byte-producing items become emission plans.
// ----------------------------------------------------------------------------
module drf_decoder
    import drf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  drf_req_t  req,
    output logic      plan_valid,
    output drf_plan_t plan,
    input  logic      plan_done
);

    logic                active_reg,    active_next;
    logic [LEN_W-1:0]    remaining_reg, remaining_next;
    logic [PADDR_W-1:0]  paddr_reg,     paddr_next;
    logic [SIZE_W-1:0]   bpos_reg,      bpos_next;
    logic [SIZE_W-1:0]   bsize_reg,     bsize_next;
    logic                plan_valid_reg, plan_valid_next;
    drf_plan_t           plan_reg,      plan_next;

    logic                accept;
    logic                load;
    logic [LEN_W-1:0]    len_c;
    logic [LEN_W-1:0]    ceil_arg;
    logic [PROD_W-1:0]   prod;
    logic [QUOT_W-1:0]   quot;
    logic [BYTE_W-1:0]   count;
    logic [LEN_W-1:0]    rem_e;
    logic [PADDR_W-1:0]  paddr_e;
    logic [SIZE_W-1:0]   bsize_e;
    logic [SIZE_W-1:0]   bpos_e;
    logic                header;
    logic [SIZE_W-1:0]   size;
    logic [SIZE_W-1:0]   bpos;
    logic [SIZE_W-1:0]   bpos_inc;
    logic                tail;

    assign req_stall = plan_valid_reg && !plan_done;
    assign accept    = req_valid && !req_stall;

    assign len_c    = (req.length > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : req.length;
    assign ceil_arg = len_c + LEN_W'(BODY_BYTES - 1);
    assign prod     = PROD_W'(ceil_arg) * PROD_W'(RECIP);
    assign quot     = prod[PROD_W-1:RECIP_SHIFT];
    assign count    = (quot > QUOT_W'(255)) ? 8'hFF : BYTE_W'(quot);

    always_comb
    begin
        // Transfer start values when no write is open
        rem_e   = active_reg ? remaining_reg : len_c;
        paddr_e = active_reg ? paddr_reg : req.address[PADDR_W-1:0];
        bsize_e = active_reg ? bsize_reg : '0;
        bpos_e  = active_reg ? bpos_reg : '0;

        header   = (bsize_e == '0);
        size     = header ? ((rem_e < LEN_W'(BODY_BYTES)) ? SIZE_W'(rem_e)
                                                          : SIZE_W'(BODY_BYTES))
                          : bsize_e;
        bpos     = header ? '0 : bpos_e;
        bpos_inc = bpos + SIZE_W'(1);
        tail     = (bpos_inc >= size);

        active_next    = active_reg;
        remaining_next = remaining_reg;
        paddr_next     = paddr_reg;
        bpos_next      = bpos_reg;
        bsize_next     = bsize_reg;
        load           = 1'b0;

        plan_next           = plan_reg;
        plan_next.is_read   = (req.command == CMD_READ);
        plan_next.count     = count;
        plan_next.address   = req.address;
        plan_next.size      = size;
        plan_next.pkt_addr  = paddr_e;
        plan_next.data      = req.data_byte;
        plan_next.data_pos  = POS_W'(POS_BODY) + POS_W'(bpos);
        plan_next.first_pos = header ? POS_W'(POS_SOF) : POS_W'(POS_BODY) + POS_W'(bpos);
        plan_next.last_pos  = tail ? POS_W'(POS_EOF) : POS_W'(POS_BODY) + POS_W'(bpos);

        if (req.command == CMD_READ)
        begin
            plan_next.first_pos = POS_W'(POS_SOF);
            plan_next.last_pos  = POS_W'(POS_EOF);
            load = accept && !active_reg;
        end
        else if (accept && (active_reg || (len_c != '0)))
        begin
            load           = 1'b1;
            remaining_next = rem_e - LEN_W'(1);
            if (tail)
            begin
                paddr_next  = paddr_e + PADDR_W'(BODY_BYTES);
                bsize_next  = '0;
                bpos_next   = '0;
                active_next = (rem_e != LEN_W'(1));
            end
            else
            begin
                paddr_next  = paddr_e;
                bsize_next  = size;
                bpos_next   = bpos_inc;
                active_next = 1'b1;
            end
        end

        if (load)
            plan_valid_next = 1'b1;
        else if (plan_done)
            plan_valid_next = 1'b0;
        else
            plan_valid_next = plan_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            remaining_reg  <= '0;
            paddr_reg      <= '0;
            bpos_reg       <= '0;
            bsize_reg      <= '0;
            plan_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            remaining_reg  <= remaining_next;
            paddr_reg      <= paddr_next;
            bpos_reg       <= bpos_next;
            bsize_reg      <= bsize_next;
            plan_valid_reg <= plan_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            plan_reg <= plan_next;
    end

    assign plan_valid = plan_valid_reg;
    assign plan       = plan_reg;

endmodule

// ===== design/drf_emitter.sv =====
// ----------------------------------------------------------------------------
// drf_emitter
// Walks plan frame positions to the output reg, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
module drf_emitter
    import drf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  drf_cfg_t  cfg,
    input  logic      plan_valid,
    input  drf_plan_t plan,
    output logic      plan_done,
    output logic      frm_valid,
    input  logic      frm_stall,
    output drf_frm_t  frm
);

    logic              at_start_reg, at_start_next;
    logic [POS_W-1:0]  pos_reg,      pos_next;
    logic [BYTE_W-1:0] sum_reg,      sum_next;
    logic              out_valid_reg, out_valid_next;
    drf_frm_t          out_reg,      out_next;

    logic              emit;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] byte_val;

    assign pos       = at_start_reg ? plan.first_pos : pos_reg;
    assign emit      = plan_valid && (!out_valid_reg || !frm_stall);
    assign plan_done = emit && (pos == plan.last_pos);

    always_comb
    begin
        byte_val = '0;
        if (!plan.is_read && (pos == plan.data_pos))
            byte_val = plan.data;
        else if (pos == POS_W'(POS_SOF))
            byte_val = FRAME_START;
        else if (pos == POS_W'(POS_COUNT))
            byte_val = plan.is_read ? plan.count : BYTE_W'(plan.size);
        else if (pos == POS_W'(POS_OPCODE))
            byte_val = plan.is_read ? cfg.read_opcode : cfg.write_opcode;
        else if (pos == POS_W'(POS_ADDR0))
            byte_val = plan.is_read ? plan.address[31:24] : plan.pkt_addr[15:8];
        else if (pos == POS_W'(POS_ADDR1))
            byte_val = plan.is_read ? plan.address[23:16] : plan.pkt_addr[7:0];
        else if (plan.is_read && (pos == POS_W'(POS_ADDR2)))
            byte_val = plan.address[15:8];
        else if (plan.is_read && (pos == POS_W'(POS_ADDR3)))
            byte_val = plan.address[7:0];
        else if (pos == POS_W'(POS_CHECKSUM))
            byte_val = sum_reg;
        else if (pos == POS_W'(POS_EOF))
            byte_val = FRAME_END;

        at_start_next  = at_start_reg;
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && frm_stall;

        if (emit)
        begin
            at_start_next         = plan_done;
            pos_next              = pos + POS_W'(1);
            out_valid_next        = 1'b1;
            out_next.frame_byte   = byte_val;
            out_next.end_of_frame = (pos == POS_W'(POS_EOF));
            out_next.last         = plan_done;
            // checksum restarts on the start byte, covers all bytes before itself
            if (pos == POS_W'(POS_SOF))
                sum_next = byte_val;
            else if (pos <= POS_W'(POS_LAST_SUM))
                sum_next = sum_reg + byte_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg  <= 1'b1;
            pos_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            at_start_reg  <= at_start_next;
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign frm_valid = out_valid_reg;
    assign frm       = out_reg;

endmodule

// ===== design/dma_request_packet_framer.sv =====
// ----------------------------------------------------------------------------
// dma_request_packet_framer
// Builds 51-byte request frames for reads and streamed write data.
// ----------------------------------------------------------------------------
// Each accepted item is decoded into a plan register and then emitted one
// frame byte per cycle, while the output is not stalled, through the output
// register. A read yields a whole frame; a write byte inside a chunk yields
// its data byte only, the first byte of a chunk adds the header before it,
// and the byte that closes a chunk adds any padding, checksum and end byte.
// A new item is taken in the cycle its predecessor's last byte is emitted;
// the first byte reaches the output through the plan register and then the
// output register. Items that cause no bytes (a read while a write is open,
// a zero-length write start) load no plan. The config port is always ready.
module dma_request_packet_framer
    import drf_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  drf_req_t               req,
    output logic                   frm_valid,
    input  logic                   frm_stall,
    output drf_frm_t               frm,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_wdata
);

    drf_cfg_t  cfg_reg, cfg_next;
    logic      plan_valid;
    drf_plan_t plan;
    logic      plan_done;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_READ_OPCODE:  cfg_next.read_opcode  = cfg_wdata;
                CFG_WRITE_OPCODE: cfg_next.write_opcode = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.read_opcode  <= 8'h00;
            cfg_reg.write_opcode <= 8'h01;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    drf_decoder u_decoder (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_done  (plan_done)
    );

    drf_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .plan_valid (plan_valid),
        .plan       (plan),
        .plan_done  (plan_done),
        .frm_valid  (frm_valid),
        .frm_stall  (frm_stall),
        .frm        (frm)
    );

endmodule
